### rtl/bli_pkg.sv
// Shared constants for the bounded list block: data width, default capacity and command codes.
package bli_pkg;

	localparam int DATA_W   = 32;
	localparam int LIST_CAP = 64;
	localparam int OP_W     = 2;
	localparam int POS_W    = 16;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND     = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE     = 2'd2;

endpackage

### rtl/bli_ram.sv
// Element store of the bounded list: one write port, one read port with registered read data.
module bli_ram #(
	parameter int DEPTH = bli_pkg::LIST_CAP,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [bli_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [bli_pkg::DATA_W-1:0] rdata
);
	import bli_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/bounded_list_insert_delete_top.sv
// Top level of the bounded list: command control, circular addressing, delete compaction, readout.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  request   | start, busy             | opcode[1:0], value[31:0], position[15:0]
//  result    | strobe (one cycle each) | element[31:0], last, empty_res, overflow
//
// A request is taken when start is high and busy is low. The update state applies it,
// then the list is read from the memory one element per cycle while busy stays high,
// and the next request is taken only after busy has dropped again; the single read port
// of the element store sets this.
// Results appear in the cycle after their reads. A delete closes its gap during the same readout.
// After reset the list is empty; the store needs no clearing. Results cannot be stalled.
module bounded_list_insert_delete_top #(
	parameter int CAPACITY = bli_pkg::LIST_CAP
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bli_pkg::OP_W-1:0]      opcode,
	input  logic signed [bli_pkg::DATA_W-1:0] value,
	input  logic [bli_pkg::POS_W-1:0]     position,
	output logic                          strobe,
	output logic signed [bli_pkg::DATA_W-1:0] element,
	output logic                          last,
	output logic                          empty_res,
	output logic                          overflow
);
	import bli_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_UPD  = 3'b010,
		ST_READ = 3'b100
	} state_t;

	state_t state_q;

	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;
	logic [AW-1:0]     head_q;
	logic [LW-1:0]     len_q;
	logic [AW-1:0]     k_q;
	logic              del_q;
	logic              ovf_q;

	logic              valid_s1;
	logic              last_s1;
	logic              empty_s1;
	logic              ovf_s1;
	logic              wb_en_s1;
	logic [AW-1:0]     wb_addr_s1;

	logic              is_insert;
	logic              ins_ok;
	logic [AW-1:0]     head_dec;
	logic [AW-1:0]     ins_addr;
	logic              skip;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              k_last;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] mem_rdata;

	// Physical address of (base + offset) in the circular store; offset never exceeds CAPACITY.
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [LW-1:0] offset);
		logic [LW:0] sum;
		sum = (LW+1)'(base) + (LW+1)'(offset);
		if (sum >= (LW+1)'(CAPACITY)) begin
			sum = sum - (LW+1)'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	assign is_insert = (op_q == OP_PUSH_FRONT) || (op_q == OP_APPEND);
	assign ins_ok    = is_insert && (len_q < LW'(CAPACITY));
	assign head_dec  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
	assign ins_addr  = (op_q == OP_PUSH_FRONT) ? head_dec : wrap_add(head_q, len_q);

	// Elements at or past a deleted position come from one slot further on.
	assign skip    = del_q && (POS_W'(k_q) >= pos_q);
	assign rd_en   = (state_q == ST_READ) && (len_q != '0);
	assign rd_addr = wrap_add(head_q, LW'(k_q) + LW'(skip));
	assign k_last  = (LW'(k_q) == len_q - LW'(1));

	// A compaction write-back never coincides with an insert write.
	assign mem_we    = ((state_q == ST_UPD) && ins_ok) || wb_en_s1;
	assign mem_waddr = wb_en_s1 ? wb_addr_s1 : ins_addr;
	assign mem_wdata = wb_en_s1 ? mem_rdata : val_q;

	bli_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			op_q  <= opcode;
			val_q <= value;
			pos_q <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			len_q      <= '0;
			k_q        <= '0;
			del_q      <= 1'b0;
			ovf_q      <= 1'b0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			empty_s1   <= 1'b0;
			ovf_s1     <= 1'b0;
			wb_en_s1   <= 1'b0;
			wb_addr_s1 <= '0;
		end else begin
			valid_s1   <= 1'b0;
			wb_en_s1   <= rd_en && skip;
			wb_addr_s1 <= wrap_add(head_q, LW'(k_q));
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					k_q   <= '0;
					ovf_q <= is_insert && !ins_ok;
					del_q <= (op_q == OP_DELETE) && (POS_W'(len_q) > pos_q);
					if (ins_ok) begin
						len_q <= len_q + LW'(1);
						if (op_q == OP_PUSH_FRONT) begin
							head_q <= head_dec;
						end
					end else if ((op_q == OP_DELETE) && (POS_W'(len_q) > pos_q)) begin
						len_q <= len_q - LW'(1);
					end
					state_q <= ST_READ;
				end
				ST_READ: begin
					valid_s1 <= 1'b1;
					ovf_s1   <= ovf_q;
					if (len_q == '0) begin
						empty_s1 <= 1'b1;
						last_s1  <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						empty_s1 <= 1'b0;
						last_s1  <= k_last;
						if (k_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = valid_s1;
	assign element   = empty_s1 ? '0 : mem_rdata;
	assign last      = last_s1;
	assign empty_res = empty_s1;
	assign overflow  = ovf_s1;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && empty_res |-> last)
		else $error("empty result without last marker");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length beyond capacity");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result directly after last result");

	a_busy_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("busy released without final result");

endmodule

### dv/bounded_list_insert_delete_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded list: random and directed commands against a queue model.
module bounded_list_insert_delete_top_tb;
	import bli_pkg::*;

	localparam int CAP = LIST_CAP;
	// Code 3 has no command behind it; the list must stay as it is.
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic signed [DATA_W-1:0] element;
		logic                     last;
		logic                     empty_res;
		logic                     overflow;
	} list_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [OP_W-1:0]          opcode = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0]         position = '0;
	wire                      busy;
	wire                      strobe;
	wire signed [DATA_W-1:0]  element;
	wire                      last;
	wire                      empty_res;
	wire                      overflow;

	bounded_list_insert_delete_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.value     (value),
		.position  (position),
		.strobe    (strobe),
		.element   (element),
		.last      (last),
		.empty_res (empty_res),
		.overflow  (overflow)
	);

	always #5 clk = ~clk;

	logic signed [DATA_W-1:0] list_image[$];
	list_result_t             pending_readouts[$];
	int                       fail_count = 0;
	int                       request_count = 0;
	int                       result_count = 0;
	int                       drop_count = 0;
	int                       peak_length = 0;
	int                       stall_cycles = 0;
	bit                       idle_enable = 1'b1;

	// Applies one command to the list image and queues the readout it must produce.
	function automatic void predict_readout(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] val, input logic [POS_W-1:0] pos);
		logic         dropped;
		list_result_t res;
		int           len;
		dropped = 1'b0;
		case (op)
			OP_PUSH_FRONT, OP_APPEND: begin
				if (list_image.size() >= CAP) begin
					dropped = 1'b1;
					drop_count++;
				end else if (op == OP_PUSH_FRONT) begin
					list_image.push_front(val);
				end else begin
					list_image.push_back(val);
				end
			end
			OP_DELETE: begin
				if (int'(pos) < list_image.size())
					list_image.delete(int'(pos));
			end
			default: begin
			end
		endcase
		len = list_image.size();
		if (len > peak_length)
			peak_length = len;
		if (len == 0) begin
			res.element = '0;
			res.last = 1'b1;
			res.empty_res = 1'b1;
			res.overflow = dropped;
			pending_readouts.push_back(res);
		end else begin
			for (int k = 0; k < len; k++) begin
				res.element = list_image[k];
				res.last = (k == len - 1);
				res.empty_res = 1'b0;
				res.overflow = dropped;
				pending_readouts.push_back(res);
			end
		end
	endfunction

	// Mostly valid indexes, with some just past the end and some anywhere in the field.
	function automatic logic [POS_W-1:0] pick_position();
		int len;
		int r;
		len = list_image.size();
		r = $urandom_range(0, 9);
		if (len == 0 || r == 9)
			return POS_W'($urandom);
		if (r < 7)
			return POS_W'($urandom_range(0, len - 1));
		if (r == 7)
			return POS_W'(len);
		return POS_W'($urandom_range(len, 65535));
	endfunction

	function automatic logic [OP_W-1:0] pick_opcode();
		int r;
		int grow;
		r = $urandom_range(0, 99);
		grow = (list_image.size() < CAP / 2) ? 55 : 40;
		if (r < grow)
			return r[0] ? OP_APPEND : OP_PUSH_FRONT;
		if (r < 98)
			return OP_DELETE;
		return OP_NOP;
	endfunction

	// Holds start until the block takes the request, then maybe idles for a short burst.
	task automatic send_request(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] val, input logic [POS_W-1:0] pos);
		start <= 1'b1;
		opcode <= op;
		value <= val;
		position <= pos;
		do
			@(posedge clk);
		while (busy);
		predict_readout(op, val, pos);
		request_count++;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_for_readouts();
		start <= 1'b0;
		while (pending_readouts.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_readout();
		send_request(OP_DELETE, 32'sd0, 16'd0);
		send_request(OP_DELETE, 32'sd0, 16'hFFFF);
		send_request(OP_NOP, 32'sh1234_5678, 16'd0);
	endtask

	task automatic test_field_extremes();
		send_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF, 16'd0);
		send_request(OP_APPEND, 32'sh8000_0000, 16'd0);
		send_request(OP_PUSH_FRONT, -32'sd1, 16'hFFFF);
		send_request(OP_APPEND, 32'sd0, 16'd0);
		send_request(OP_APPEND, 32'sh5555_AAAA, 16'd0);
		// Index equal to the length and the top index both leave the list alone.
		send_request(OP_DELETE, 32'sd0, 16'd5);
		send_request(OP_DELETE, -32'sd1, 16'hFFFF);
		send_request(OP_DELETE, 32'sd0, 16'd2);
		send_request(OP_DELETE, 32'sd0, 16'd3);
		send_request(OP_DELETE, 32'sd0, 16'd0);
		send_request(OP_NOP, 32'sh7FFF_FFFF, 16'd1);
		send_request(OP_DELETE, 32'sd0, 16'd0);
		send_request(OP_DELETE, 32'sd0, 16'd0);
	endtask

	task automatic test_fill_and_overflow();
		while (list_image.size() < CAP) begin
			if ($urandom_range(0, 9) == 0)
				send_request(OP_DELETE, $urandom, pick_position());
			else
				send_request($urandom_range(0, 1) ? OP_APPEND : OP_PUSH_FRONT, $urandom,
					POS_W'($urandom));
		end
		repeat (4)
			send_request($urandom_range(0, 1) ? OP_APPEND : OP_PUSH_FRONT, $urandom,
				POS_W'($urandom));
		send_request(OP_NOP, $urandom, POS_W'($urandom));
		wait_for_readouts();
	endtask

	task automatic test_drain();
		while (list_image.size() > 0)
			send_request(OP_DELETE, $urandom, pick_position());
		send_request(OP_DELETE, $urandom, pick_position());
	endtask

	task automatic test_mixed_random();
		for (int i = 0; i < 50; i++) begin
			idle_enable = ((i / 20) % 2 == 0);
			send_request(pick_opcode(), $urandom, pick_position());
		end
		idle_enable = 1'b1;
	endtask

	task automatic test_back_to_back();
		idle_enable = 1'b0;
		repeat (30)
			send_request(pick_opcode(), $urandom, pick_position());
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (pending_readouts.size() == 0) begin
				$error("result with no request pending: element %0d last %0b", element, last);
				fail_count++;
			end else begin
				want = pending_readouts.pop_front();
				result_count++;
				if (element !== want.element) begin
					$error("element: expected %0d, got %0d", want.element, element);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					fail_count++;
				end
				if (empty_res !== want.empty_res) begin
					$error("empty_res: expected %0b, got %0b", want.empty_res, empty_res);
					fail_count++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, overflow);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$error("no request or result accepted for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_readout();
		test_field_extremes();
		test_fill_and_overflow();
		test_drain();
		test_mixed_random();
		test_back_to_back();
		wait_for_readouts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests and checked %0d results; list grew to %0d entries.",
			request_count, result_count, peak_length);
		$display("Inserts dropped on a full list: %0d; mismatches: %0d.", drop_count, fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
